// ===== sv/imucf_pkg.sv =====
// shared types and constants for the pitch/roll complementary filter
`default_nettype none
package imucf_pkg;

  localparam int AngleMax = 11796480;
  localparam int YawK     = 1172079;
  localparam int DegK     = 3754951;
  localparam int CordicStart = 652032874;
  localparam int MaxSteps = 24;

  // configuration register indexes
  localparam logic [2:0] REG_OFS_X  = 3'd0;
  localparam logic [2:0] REG_OFS_Y  = 3'd1;
  localparam logic [2:0] REG_OFS_Z  = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_WEIGHT = 3'd4;
  localparam logic [2:0] REG_PTRIM  = 3'd5;
  localparam logic [2:0] REG_RTRIM  = 3'd6;

  // datapath operation codes
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch sample, corrected rates
    OP_GYRO,     // multiply rate by gain, integrate
    OP_SINARG,   // sine argument
    OP_SIN,      // one cordic rotation step
    OP_CPL_P,    // pitch coupling
    OP_CPL_R,    // roll coupling
    OP_SQ,       // squares for one axis
    OP_SQRT,     // one square root step
    OP_ATAN,     // one cordic vectoring step
    OP_DEG,      // radians to degrees, trim
    OP_BLEND_M,  // blend products
    OP_BLEND     // blend sum, store state
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       init;  // first step of the square root op
    logic       sel;   // 0 pitch axis, 1 roll axis
    logic [4:0] idx;   // cordic step index
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } sts_t;

  function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 32'sd843314856;  5'd1: atan_lut = 32'sd497837829;
      5'd2: atan_lut = 32'sd263043836;  5'd3: atan_lut = 32'sd133525158;
      5'd4: atan_lut = 32'sd67021686;   5'd5: atan_lut = 32'sd33543515;
      5'd6: atan_lut = 32'sd16775850;   5'd7: atan_lut = 32'sd8388437;
      5'd8: atan_lut = 32'sd4194282;    5'd9: atan_lut = 32'sd2097149;
      5'd10: atan_lut = 32'sd1048575;   5'd11: atan_lut = 32'sd524287;
      5'd12: atan_lut = 32'sd262143;    5'd13: atan_lut = 32'sd131071;
      5'd14: atan_lut = 32'sd65535;     5'd15: atan_lut = 32'sd32767;
      5'd16: atan_lut = 32'sd16383;     5'd17: atan_lut = 32'sd8191;
      5'd18: atan_lut = 32'sd4095;      5'd19: atan_lut = 32'sd2047;
      5'd20: atan_lut = 32'sd1023;      5'd21: atan_lut = 32'sd511;
      5'd22: atan_lut = 32'sd255;       5'd23: atan_lut = 32'sd127;
      default: atan_lut = 32'sd0;
    endcase
  endfunction

  function automatic logic signed [24:0] sat25(input logic signed [39:0] v);
    if (v > 40'sd11796480) sat25 = 25'sd11796480;
    else if (v < -40'sd11796480) sat25 = -25'sd11796480;
    else sat25 = v[24:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/imucf_if.sv =====
// valid/ready channel interfaces: sample, result, configuration
`default_nettype none
interface imucf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  modport source (output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink (input valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
                output ready);
endinterface

interface imucf_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] pitch;
  logic signed [24:0] roll;
  modport source (output valid, pitch, roll, input ready);
  modport sink (input valid, pitch, roll, output ready);
endinterface

interface imucf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/imu_pitch_roll_complementary_filter.sv =====
// top level of the pitch/roll complementary filter
//
//  channel  dir  beat contents
//  in_ch    in   acc_x/y/z, gyro_x/y/z
//  out_ch   out  pitch, roll
//  cfg_ch   in   index, data
//
// with no stall the shared cordic runs three times per item and the square root
// runs twice; single states load, integrate, set up the sine argument, couple,
// square, convert and blend, and then the result beat is offered.
// a new sample is taken only after the result beat leaves; the output holds
// while out ready is low. reset clears the angles and loads default registers.
`default_nettype none
module imu_pitch_roll_complementary_filter import imucf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input wire clk_i,
  input wire rst_ni,
  imucf_in_if.sink    in_ch,
  imucf_out_if.source out_ch,
  imucf_cfg_if.sink   cfg_ch
);

  logic signed [15:0] ofs_x_q, ofs_y_q, ofs_z_q;
  logic        [31:0] gain_q;
  logic        [15:0] weight_q;
  logic signed [24:0] ptrim_q, rtrim_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_x_q <= '0; ofs_y_q <= '0; ofs_z_q <= '0;
      gain_q <= 32'd262423; weight_q <= 16'd26;
      ptrim_q <= '0; rtrim_q <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_OFS_X:  ofs_x_q  <= cfg_ch.data[15:0];
        REG_OFS_Y:  ofs_y_q  <= cfg_ch.data[15:0];
        REG_OFS_Z:  ofs_z_q  <= cfg_ch.data[15:0];
        REG_GAIN:   gain_q   <= cfg_ch.data;
        REG_WEIGHT: weight_q <= cfg_ch.data[15:0];
        REG_PTRIM:  ptrim_q  <= cfg_ch.data[24:0];
        REG_RTRIM:  rtrim_q  <= cfg_ch.data[24:0];
        default: ;
      endcase
    end
  end

  imucf_ctrl #(.Steps(CORDIC_STEPS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  imucf_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .acc_x_i(in_ch.acc_x), .acc_y_i(in_ch.acc_y), .acc_z_i(in_ch.acc_z),
    .gyro_x_i(in_ch.gyro_x), .gyro_y_i(in_ch.gyro_y), .gyro_z_i(in_ch.gyro_z),
    .ofs_x_i(ofs_x_q), .ofs_y_i(ofs_y_q), .ofs_z_i(ofs_z_q),
    .gain_i(gain_q), .weight_i(weight_q),
    .ptrim_i(ptrim_q), .rtrim_i(rtrim_q),
    .pitch_o(out_ch.pitch), .roll_o(out_ch.roll)
  );

endmodule
`default_nettype wire

// ===== sv/imucf_ctrl.sv =====
// sequencer that steps the datapath through one sample
`default_nettype none
module imucf_ctrl import imucf_pkg::*; #(
  parameter int Steps = 16
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int NSteps = (Steps < MaxSteps) ? Steps : MaxSteps;

  typedef enum logic [3:0] {
    S_IDLE, S_GYRO, S_SINARG, S_SIN, S_CPLP, S_CPLR, S_SQ, S_SQRT,
    S_ATAN, S_DEG, S_BLM, S_BL, S_OUT
  } state_e;

  state_e     state_q;
  logic [4:0] idx_q;
  logic       sel_q;
  logic       init_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // command decode
  always_comb begin
    cmd_o.init = init_q;
    cmd_o.sel  = sel_q;
    cmd_o.idx  = idx_q;
    case (state_q)
      S_IDLE:   cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_GYRO:   cmd_o.op = OP_GYRO;
      S_SINARG: cmd_o.op = OP_SINARG;
      S_SIN:    cmd_o.op = OP_SIN;
      S_CPLP:   cmd_o.op = OP_CPL_P;
      S_CPLR:   cmd_o.op = OP_CPL_R;
      S_SQ:     cmd_o.op = OP_SQ;
      S_SQRT:   cmd_o.op = OP_SQRT;
      S_ATAN:   cmd_o.op = OP_ATAN;
      S_DEG:    cmd_o.op = OP_DEG;
      S_BLM:    cmd_o.op = OP_BLEND_M;
      S_BL:     cmd_o.op = OP_BLEND;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      sel_q   <= 1'b0;
      init_q  <= 1'b0;
    end else begin
      init_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_GYRO;
        S_GYRO: state_q <= S_SINARG;
        S_SINARG: begin
          state_q <= S_SIN;
          idx_q   <= '0;
        end
        S_SIN: begin
          if (idx_q == 5'(NSteps - 1)) state_q <= S_CPLP;
          else idx_q <= idx_q + 5'd1;
        end
        S_CPLP: state_q <= S_CPLR;
        S_CPLR: begin
          state_q <= S_SQ;
          sel_q   <= 1'b0;
        end
        S_SQ: begin
          state_q <= S_SQRT;
          init_q  <= 1'b1;
        end
        S_SQRT: begin
          if (!init_q && sts_i.sqrt_done) begin
            state_q <= S_ATAN;
            idx_q   <= '0;
          end
        end
        S_ATAN: begin
          if (idx_q == 5'(NSteps - 1)) state_q <= S_DEG;
          else idx_q <= idx_q + 5'd1;
        end
        S_DEG: begin
          if (sel_q) state_q <= S_BLM;
          else begin
            sel_q   <= 1'b1;
            state_q <= S_SQ;
          end
        end
        S_BLM: state_q <= S_BL;
        S_BL:  state_q <= S_OUT;
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/imucf_dp.sv =====
// arithmetic datapath: integration, sine, sqrt, atan2, blend
`default_nettype none
module imucf_dp import imucf_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  wire signed [15:0]  acc_x_i,
  input  wire signed [15:0]  acc_y_i,
  input  wire signed [15:0]  acc_z_i,
  input  wire signed [15:0]  gyro_x_i,
  input  wire signed [15:0]  gyro_y_i,
  input  wire signed [15:0]  gyro_z_i,
  input  wire signed [15:0]  ofs_x_i,
  input  wire signed [15:0]  ofs_y_i,
  input  wire signed [15:0]  ofs_z_i,
  input  wire        [31:0]  gain_i,
  input  wire        [15:0]  weight_i,
  input  wire signed [24:0]  ptrim_i,
  input  wire signed [24:0]  rtrim_i,
  output logic signed [24:0] pitch_o,
  output logic signed [24:0] roll_o
);

  // sample and state registers
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [16:0] gx_q, gy_q, gz_q;
  logic signed [24:0] pst_q, rst_q;     // stored angles
  logic               started_q;
  logic signed [24:0] p_q, r_q;         // working gyro angles
  logic signed [24:0] pa_q, ra_q;       // accelerometer angles
  // cordic registers (shared by sine and atan2)
  logic signed [33:0] cx_q, cy_q, cz_q;
  // square root
  logic [31:0] sn_q, sroot_q, sbit_q;
  logic signed [15:0] sa_q;
  // blend products
  logic signed [41:0] bp_q, br_q;

  logic signed [15:0] a_ax, b_ax, c_ax;
  assign a_ax = cmd_i.sel ? ax_q : ay_q;
  assign b_ax = cmd_i.sel ? ay_q : ax_q;
  assign c_ax = az_q;

  assign sts_o.sqrt_done = (sbit_q == '0);
  assign pitch_o = pst_q;
  assign roll_o  = rst_q;

  // shared combinational terms
  logic signed [49:0] prod_p, prod_r;
  logic signed [33:0] xs, ys, atn;
  logic signed [55:0] cpl;
  logic signed [38:0] sarg;
  logic signed [59:0] degp;
  logic [32:0] sum_rb;

  always_comb begin
    prod_p = gx_q * $signed({1'b0, gain_i});
    prod_r = gy_q * $signed({1'b0, gain_i});
    xs  = cx_q >>> cmd_i.idx;
    ys  = cy_q >>> cmd_i.idx;
    atn = 34'(atan_lut(cmd_i.idx));
    cpl = (cmd_i.op == OP_CPL_P) ? r_q * cy_q : p_q * cy_q;
    sarg = gz_q * 39'sd1172079;
    degp = cz_q * 60'sd3754951;
    sum_rb = {1'b0, sroot_q} + {1'b0, sbit_q};
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q     <= '0;
      rst_q     <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.op == OP_BLEND) begin
      if (!started_q) begin
        pst_q     <= pa_q;
        rst_q     <= ra_q;
        started_q <= 1'b1;
      end else begin
        pst_q <= sat25(40'((bp_q + 42'sd32768) >>> 16));
        rst_q <= sat25(40'((br_q + 42'sd32768) >>> 16));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        ax_q <= acc_x_i;
        ay_q <= acc_y_i;
        az_q <= acc_z_i;
        gx_q <= 17'(gyro_x_i) - 17'(ofs_x_i);
        gy_q <= 17'(gyro_y_i) - 17'(ofs_y_i);
        gz_q <= 17'(gyro_z_i) - 17'(ofs_z_i);
      end
      OP_GYRO: begin
        p_q <= sat25(40'(pst_q) + 40'((prod_p + 50'sd32768) >>> 16));
        r_q <= sat25(40'(rst_q) + 40'((prod_r + 50'sd32768) >>> 16));
      end
      OP_SINARG: begin
        cx_q <= 34'sd652032874;
        cy_q <= '0;
        cz_q <= 34'((sarg + 39'sd512) >>> 10);
      end
      OP_SIN: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - atn;
        end else begin
          cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + atn;
        end
      end
      OP_CPL_P: p_q <= sat25(40'(p_q) + 40'((cpl + 56'sd536870912) >>> 30));
      OP_CPL_R: r_q <= sat25(40'(r_q) - 40'((cpl + 56'sd536870912) >>> 30));
      OP_SQ: begin
        sn_q    <= 32'(b_ax * b_ax) + 32'(c_ax * c_ax);
        sroot_q <= '0;
        sbit_q  <= 32'h4000_0000;
        sa_q    <= a_ax;
      end
      OP_SQRT: begin
        if (sbit_q != '0) begin
          if (sbit_q > sn_q && sroot_q == '0) begin
            sbit_q <= sbit_q >> 2;
          end else begin
            if ({1'b0, sn_q} >= sum_rb) begin
              sn_q    <= sn_q - sum_rb[31:0];
              sroot_q <= (sroot_q >> 1) + sbit_q;
            end else begin
              sroot_q <= sroot_q >> 1;
            end
            sbit_q <= sbit_q >> 2;
          end
        end else begin
          cx_q <= {2'b00, sroot_q[17:0], 14'd0};
          cy_q <= {{4{sa_q[15]}}, sa_q, 14'd0};
          cz_q <= '0;
        end
      end
      OP_ATAN: begin
        if (!cy_q[33]) begin
          cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + atn;
        end else begin
          cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - atn;
        end
      end
      OP_DEG: begin
        if (cmd_i.sel) begin
          if (sa_q == '0 && sroot_q == '0)
            ra_q <= sat25(-40'(rtrim_i));
          else
            ra_q <= sat25(-40'((degp + 60'sd536870912) >>> 30) - 40'(rtrim_i));
        end else begin
          if (sa_q == '0 && sroot_q == '0)
            pa_q <= sat25(-40'(ptrim_i));
          else
            pa_q <= sat25(40'((degp + 60'sd536870912) >>> 30) - 40'(ptrim_i));
        end
      end
      OP_BLEND_M: begin
        bp_q <= 42'(p_q * $signed({1'b0, 17'(17'h10000 - {1'b0, weight_i})}))
              + 42'(pa_q * $signed({1'b0, weight_i}));
        br_q <= 42'(r_q * $signed({1'b0, 17'(17'h10000 - {1'b0, weight_i})}))
              + 42'(ra_q * $signed({1'b0, weight_i}));
      end
      default: sa_q <= sa_q;
    endcase
  end

endmodule
`default_nettype wire
